[design/assert_macros.svh]
// Assertion macros used by the checker module.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Concurrent assertion, disabled while reset is high.
`define PRWD_ASSERT(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Concurrent assertion that also holds across reset.
`define PRWD_ASSERT_ALWAYS(label, clk, prop, msg) \
   label: assert property (@(posedge clk) prop) else $error(msg);

`endif

[design/prwd_pkg.sv]
// Types and constants of the pixel random walk block.
package prwd_pkg;

   localparam int INDEX_BITS      = 10;
   localparam int COORD_PORT_BITS = 12;
   localparam int SIZE_BITS       = 13;
   localparam int STEP_BITS       = 8;
   localparam int CSR_DATA_BITS   = 32;
   localparam int CSR_ADDR_BITS   = 5;
   localparam int REG_INDEX_BITS  = 3;

   localparam int MAG_DIV       = 10;
   localparam int MAG_CAP       = 7;
   localparam int MAG_STEP_BITS = 3;

   localparam logic [SIZE_BITS-1:0] SCREEN_WIDTH_RESET  = 13'd640;
   localparam logic [SIZE_BITS-1:0] SCREEN_HEIGHT_RESET = 13'd480;
   localparam logic [STEP_BITS-1:0] STEP_WIDTH_RESET    = 8'd1;

   typedef enum logic {
      ACTION_LOAD = 1'b0,
      ACTION_STEP = 1'b1
   } action_type;

   typedef enum logic [1:0] {
      DIR_EAST  = 2'd0,
      DIR_WEST  = 2'd1,
      DIR_SOUTH = 2'd2,
      DIR_NORTH = 2'd3
   } dir_type;

   typedef enum logic [REG_INDEX_BITS-1:0] {
      REG_SCREEN_WIDTH  = 3'd0,
      REG_SCREEN_HEIGHT = 3'd1,
      REG_WALK_MODE     = 3'd2,
      REG_WIDTH_EAST    = 3'd3,
      REG_WIDTH_WEST    = 3'd4,
      REG_WIDTH_SOUTH   = 3'd5,
      REG_WIDTH_NORTH   = 3'd6
   } reg_index_type;

   typedef struct packed {
      action_type                  action;
      logic [INDEX_BITS-1:0]       particle_index;
      logic [COORD_PORT_BITS-1:0]  load_x;
      logic [COORD_PORT_BITS-1:0]  load_y;
      dir_type                     direction;
      logic [COORD_PORT_BITS-1:0]  target_x;
      logic [COORD_PORT_BITS-1:0]  target_y;
   } req_type;

   typedef struct packed {
      logic [INDEX_BITS-1:0]       out_index;
      logic [COORD_PORT_BITS-1:0]  new_x;
      logic [COORD_PORT_BITS-1:0]  new_y;
   } rsp_type;

endpackage

[design/prwd_ram.sv]
// Generic single-write, single-read RAM with registered read data.
module prwd_ram #(
   parameter int WIDTH = 24,
   parameter int DEPTH = 1024,
   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
)(
   input  logic             clock,
   input  logic             we,
   input  logic [AW-1:0]    waddr,
   input  logic [WIDTH-1:0] wdata,
   input  logic             re,
   input  logic [AW-1:0]    raddr,
   output logic [WIDTH-1:0] rdata
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      if (re) begin
         rdata_ff <= mem[raddr];
      end
   end

   assign rdata = rdata_ff;

endmodule

[design/pixel_random_walk_discrete.sv]
// Pipeline: an accepted request is registered in stage 1, its result in the output
// register; a stalled result holds both until rsp_ready. Throughput: one item per cycle
// unless the output stalls; each item is one read-modify-write of the position RAM
// (read at accept, write as it leaves stage 1, same-entry hazards forwarded).
// Reset: synchronous, clears the pipeline and loads register defaults; the position
// RAM is not cleared and an entry reads undefined until it is loaded.
module pixel_random_walk_discrete
   import prwd_pkg::*;
#(
   parameter int PARTICLE_COUNT = 1024,
   parameter int COORD_BITS     = 12
)(
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   output logic                     req_ready,
   input  req_type                  req_data,
   output logic                     rsp_valid,
   input  logic                     rsp_ready,
   output rsp_type                  rsp_data,
   input  logic                     psel,
   input  logic                     penable,
   input  logic                     pwrite,
   input  logic [CSR_ADDR_BITS-1:0] paddr,
   input  logic [CSR_DATA_BITS-1:0] pwdata,
   output logic [CSR_DATA_BITS-1:0] prdata,
   output logic                     pready
);

   localparam int AW = (PARTICLE_COUNT > 1) ? $clog2(PARTICLE_COUNT) : 1;
   localparam int CB = COORD_BITS;
   localparam int DW = (CB > COORD_PORT_BITS) ? CB : COORD_PORT_BITS;
   localparam int EW = ((CB > STEP_BITS) ? CB : STEP_BITS) + 1;
   localparam int LW = (EW > SIZE_BITS) ? EW : SIZE_BITS;
   localparam logic [LW-1:0] COORD_MAX = LW'({CB{1'b1}});

   // configuration registers
   logic [SIZE_BITS-1:0] screen_width_ff;
   logic [SIZE_BITS-1:0] screen_height_ff;
   logic                 walk_mode_ff;
   logic [STEP_BITS-1:0] width_east_ff;
   logic [STEP_BITS-1:0] width_west_ff;
   logic [STEP_BITS-1:0] width_south_ff;
   logic [STEP_BITS-1:0] width_north_ff;
   logic                 csr_write;
   reg_index_type        csr_index;

   assign pready    = 1'b1;
   assign csr_write = psel && penable && pwrite;
   assign csr_index = reg_index_type'(paddr[CSR_ADDR_BITS-1:2]);

   always_ff @(posedge clock) begin
      if (reset) begin
         screen_width_ff  <= SCREEN_WIDTH_RESET;
         screen_height_ff <= SCREEN_HEIGHT_RESET;
         walk_mode_ff     <= 1'b0;
         width_east_ff    <= STEP_WIDTH_RESET;
         width_west_ff    <= STEP_WIDTH_RESET;
         width_south_ff   <= STEP_WIDTH_RESET;
         width_north_ff   <= STEP_WIDTH_RESET;
      end else if (csr_write) begin
         case (csr_index)
            REG_SCREEN_WIDTH:  screen_width_ff  <= pwdata[SIZE_BITS-1:0];
            REG_SCREEN_HEIGHT: screen_height_ff <= pwdata[SIZE_BITS-1:0];
            REG_WALK_MODE:     walk_mode_ff     <= pwdata[0];
            REG_WIDTH_EAST:    width_east_ff    <= pwdata[STEP_BITS-1:0];
            REG_WIDTH_WEST:    width_west_ff    <= pwdata[STEP_BITS-1:0];
            REG_WIDTH_SOUTH:   width_south_ff   <= pwdata[STEP_BITS-1:0];
            REG_WIDTH_NORTH:   width_north_ff   <= pwdata[STEP_BITS-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      case (csr_index)
         REG_SCREEN_WIDTH:  prdata = CSR_DATA_BITS'(screen_width_ff);
         REG_SCREEN_HEIGHT: prdata = CSR_DATA_BITS'(screen_height_ff);
         REG_WALK_MODE:     prdata = CSR_DATA_BITS'(walk_mode_ff);
         REG_WIDTH_EAST:    prdata = CSR_DATA_BITS'(width_east_ff);
         REG_WIDTH_WEST:    prdata = CSR_DATA_BITS'(width_west_ff);
         REG_WIDTH_SOUTH:   prdata = CSR_DATA_BITS'(width_south_ff);
         REG_WIDTH_NORTH:   prdata = CSR_DATA_BITS'(width_north_ff);
         default:           prdata = '0;
      endcase
   end

   // pipeline control
   logic          req_accept;
   logic          out_free;
   logic          s1_move;
   logic          s1_valid_ff;
   req_type       s1_req_ff;
   logic          s1_in_range_ff;
   logic          s1_in_range_in;
   logic          s1_fwd_ff;
   logic          s1_fwd_in;
   logic [CB-1:0] fwd_x_ff;
   logic [CB-1:0] fwd_y_ff;
   logic          rsp_valid_ff;
   rsp_type       rsp_data_ff;
   rsp_type       rsp_data_in;

   assign out_free   = !rsp_valid_ff || rsp_ready;
   assign s1_move    = s1_valid_ff && out_free;
   assign req_ready  = !s1_valid_ff || out_free;
   assign req_accept = req_valid && req_ready;

   // position RAM: {x, y}
   logic            mem_we;
   logic [AW-1:0]   mem_waddr;
   logic [2*CB-1:0] mem_wdata;
   logic [AW-1:0]   mem_raddr;
   logic [2*CB-1:0] mem_rdata;
   logic [CB-1:0]   new_x;
   logic [CB-1:0]   new_y;

   assign mem_we    = s1_move && s1_in_range_ff;
   assign mem_waddr = AW'(s1_req_ff.particle_index);
   assign mem_wdata = {new_x, new_y};
   assign mem_raddr = AW'(req_data.particle_index);

   prwd_ram #(
      .WIDTH (2*CB),
      .DEPTH (PARTICLE_COUNT)
   ) u_pos_ram (
      .clock (clock),
      .we    (mem_we),
      .waddr (mem_waddr),
      .wdata (mem_wdata),
      .re    (req_accept),
      .raddr (mem_raddr),
      .rdata (mem_rdata)
   );

   assign s1_in_range_in = int'(req_data.particle_index) < PARTICLE_COUNT;
   assign s1_fwd_in      = mem_we && (mem_waddr == mem_raddr);

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (req_accept) begin
         s1_valid_ff <= 1'b1;
      end else if (s1_move) begin
         s1_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (req_accept) begin
         s1_req_ff      <= req_data;
         s1_in_range_ff <= s1_in_range_in;
         s1_fwd_ff      <= s1_fwd_in;
         fwd_x_ff       <= new_x;
         fwd_y_ff       <= new_y;
      end
   end

   // step datapath
   logic [CB-1:0]            cur_x;
   logic [CB-1:0]            cur_y;
   logic                     is_y;
   logic                     move_up;
   logic [CB-1:0]            coord;
   logic [COORD_PORT_BITS-1:0] tgt;
   logic [SIZE_BITS-1:0]     size;
   logic [DW-1:0]            coord_w;
   logic [DW-1:0]            tgt_w;
   logic                     toward;
   logic [DW-1:0]            distance;
   logic [MAG_STEP_BITS-1:0] mag_step;
   logic [STEP_BITS-1:0]     static_step;
   logic [STEP_BITS-1:0]     step;
   logic [EW-1:0]            sum;
   logic [EW-1:0]            diff;
   logic [LW-1:0]            lim_raw;
   logic [LW-1:0]            lim;
   logic                     undo_up;
   logic                     undo_down;
   logic [CB-1:0]            moved;

   assign cur_x = s1_fwd_ff ? fwd_x_ff : mem_rdata[2*CB-1:CB];
   assign cur_y = s1_fwd_ff ? fwd_y_ff : mem_rdata[CB-1:0];

   assign is_y    = (s1_req_ff.direction == DIR_SOUTH) || (s1_req_ff.direction == DIR_NORTH);
   assign move_up = (s1_req_ff.direction == DIR_EAST) || (s1_req_ff.direction == DIR_SOUTH);
   assign coord   = is_y ? cur_y : cur_x;
   assign tgt     = is_y ? s1_req_ff.target_y : s1_req_ff.target_x;
   assign size    = is_y ? screen_height_ff : screen_width_ff;
   assign coord_w = DW'(coord);
   assign tgt_w   = DW'(tgt);
   assign toward  = move_up ? (tgt_w > coord_w) : (coord_w > tgt_w);
   assign distance = move_up ? (tgt_w - coord_w) : (coord_w - tgt_w);

   // distance / 10 + 1, capped, or 1 when not moving toward the target: count the thresholds passed
   always_comb begin
      mag_step = MAG_STEP_BITS'(1);
      for (int k = 1; k < MAG_CAP; k++) begin
         if (distance >= DW'(MAG_DIV * k)) begin
            mag_step = mag_step + MAG_STEP_BITS'(1);
         end
      end
      if (!toward) begin
         mag_step = MAG_STEP_BITS'(1);
      end
   end

   always_comb begin
      case (s1_req_ff.direction)
         DIR_EAST:  static_step = width_east_ff;
         DIR_WEST:  static_step = width_west_ff;
         DIR_SOUTH: static_step = width_south_ff;
         DIR_NORTH: static_step = width_north_ff;
         default:   static_step = width_east_ff;
      endcase
   end

   assign step    = walk_mode_ff ? STEP_BITS'(mag_step) : static_step;
   assign sum     = EW'(coord) + EW'(step);
   assign diff    = EW'(coord) - EW'(step);
   assign lim_raw = LW'(size) - LW'(1);
   assign lim     = (lim_raw > COORD_MAX) ? COORD_MAX : lim_raw;
   assign undo_up = (size == '0) ||
                    (walk_mode_ff ? (LW'(sum) > lim) : (LW'(sum) >= lim));
   assign undo_down = EW'(step) > EW'(coord);

   always_comb begin
      if (move_up) begin
         moved = undo_up ? coord : CB'(sum);
      end else begin
         moved = undo_down ? coord : CB'(diff);
      end
   end

   always_comb begin
      if (s1_req_ff.action == ACTION_LOAD) begin
         new_x = CB'(s1_req_ff.load_x);
         new_y = CB'(s1_req_ff.load_y);
      end else begin
         new_x = is_y ? cur_x : moved;
         new_y = is_y ? moved : cur_y;
      end
   end

   always_comb begin
      rsp_data_in.out_index = s1_req_ff.particle_index;
      rsp_data_in.new_x     = s1_in_range_ff ? COORD_PORT_BITS'(new_x) : '0;
      rsp_data_in.new_y     = s1_in_range_ff ? COORD_PORT_BITS'(new_y) : '0;
   end

   // output register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (s1_move) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (s1_move) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

[design/prwd_checker.sv]
// Port-level checker for the pixel random walk block, bound to the top level.
`include "assert_macros.svh"

module prwd_checker
   import prwd_pkg::*;
#(
   parameter int PARTICLE_COUNT = 1024
)(
   input logic                     clock,
   input logic                     reset,
   input logic                     req_valid,
   input logic                     req_ready,
   input logic                     rsp_valid,
   input logic                     rsp_ready,
   input rsp_type                  rsp_data
);

   `PRWD_ASSERT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data), "rsp beat dropped or changed while stalled")

   `PRWD_ASSERT_ALWAYS(a_reset_idle, clock, reset |=> req_ready && !rsp_valid, "pipeline not empty after reset")

   `PRWD_ASSERT(a_req_to_rsp, clock, reset, req_valid && req_ready |=> ##1 rsp_valid, "no result two cycles after an accepted beat")

   `PRWD_ASSERT(a_out_of_range_zero, clock, reset, rsp_valid && (int'(rsp_data.out_index) >= PARTICLE_COUNT) |-> (rsp_data.new_x == '0) && (rsp_data.new_y == '0), "out-of-range index with nonzero position")

endmodule

bind pixel_random_walk_discrete prwd_checker #(
   .PARTICLE_COUNT (PARTICLE_COUNT)
) u_prwd_checker (.*);
